>>> rtl/cuc_pkg.sv
// package: constants, payload types and helpers for the ccd column unscrambler
`default_nettype none
package cuc_pkg;

   localparam int MAP_DEPTH      = 8544;
   localparam int FIXED_OUT_SIZE = 4096;
   localparam int ROW_LIMIT      = 8192;
   localparam int MAP_IDX_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W     = 4;

   localparam logic [1:0] MODE_PASS = 2'd0;
   localparam logic [1:0] MODE_KEEP = 2'd1;
   localparam logic [1:0] MODE_DROP = 2'd2;

   localparam logic KIND_MAP   = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_IN_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IN_HEIGHT = 2'd2;

   localparam logic [1:0]  MODE_RESET      = MODE_PASS;
   localparam logic [13:0] IN_WIDTH_RESET  = 14'd8544;
   localparam logic [13:0] IN_HEIGHT_RESET = 14'd2048;

   localparam int MAP_COL_MSB = 13;
   localparam int MAP_ANC_BIT = 14;
   localparam int MAP_FLIP_BIT = 15;

   typedef struct packed {
      logic               kind;
      logic [13:0]        map_index;
      logic [15:0]        map_value;
      logic signed [15:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [26:0]        write_address;
      logic signed [15:0] pixel_out;
      logic               write_enable;
      logic               out_of_range;
      logic               frame_last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        entry;
      logic [13:0]        col;
      logic [12:0]        row;
      logic signed [15:0] pixel;
      logic               last;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type data;
   } q_push_type;

   function automatic logic [14:0] eff_width(input logic [13:0] w);
      logic [14:0] v;
      v = {1'b0, w};
      if (v == 15'd0) v = 15'd1;
      if (v > 15'(MAP_DEPTH)) v = 15'(MAP_DEPTH);
      return v;
   endfunction

   function automatic logic [13:0] eff_height(input logic [13:0] h);
      logic [13:0] v;
      v = h;
      if (v == 14'd0) v = 14'd1;
      if (v > 14'(ROW_LIMIT)) v = 14'(ROW_LIMIT);
      return v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ccd_readout_column_unscrambler.sv
// top level: register port, front end, queue and back end of the column unscrambler
// an accepted pixel passes the map read stage, the queue, the address stage and the result register
// throughput: one item per cycle while req_stall is low; the map memory has one port shared by loads and reads
// map loads give no result
// reset: synchronous, clears counters, queue and valid flags; registers return to defaults
// the column map is not cleared by reset
`default_nettype none
module ccd_readout_column_unscrambler (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire cuc_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output cuc_pkg::rsp_type                   rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [cuc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic [1:0]  mode_ff;
   logic [13:0] in_width_ff;
   logic [13:0] in_height_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   cuc_pkg::q_push_type  q_push;
   cuc_pkg::q_entry_type q_head;
   logic                 q_head_valid;
   logic                 q_pop;
   logic [cuc_pkg::QCNT_W-1:0] q_count;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cuc_pkg::MODE_RESET;
         in_width_ff  <= cuc_pkg::IN_WIDTH_RESET;
         in_height_ff <= cuc_pkg::IN_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            cuc_pkg::REG_MODE:      mode_ff      <= pwdata[1:0];
            cuc_pkg::REG_IN_WIDTH:  in_width_ff  <= pwdata[13:0];
            cuc_pkg::REG_IN_HEIGHT: in_height_ff <= pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         cuc_pkg::REG_MODE:      prdata = {30'd0, mode_ff};
         cuc_pkg::REG_IN_WIDTH:  prdata = {18'd0, in_width_ff};
         cuc_pkg::REG_IN_HEIGHT: prdata = {18'd0, in_height_ff};
         default:                prdata = 32'd0;
      endcase
   end

   cuc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .cfg_in_width  (in_width_ff),
      .cfg_in_height (in_height_ff),
      .q_count       (q_count),
      .q_push        (q_push)
   );

   cuc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head),
      .count      (q_count)
   );

   cuc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (q_head_valid),
      .head          (q_head),
      .pop           (q_pop),
      .cfg_mode      (mode_ff),
      .cfg_in_width  (in_width_ff),
      .cfg_in_height (in_height_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/cuc_front.sv
// front end: accepts items, loads the column map, runs the counters, reads the map
`default_nettype none
module cuc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire cuc_pkg::req_type          req_data,
   input  wire logic [13:0]               cfg_in_width,
   input  wire logic [13:0]               cfg_in_height,
   input  wire logic [cuc_pkg::QCNT_W-1:0] q_count,
   output cuc_pkg::q_push_type            q_push
);

   localparam int QCNT_SUM_W = cuc_pkg::QCNT_W + 1;

   logic [15:0] map_mem [cuc_pkg::MAP_DEPTH];

   logic [13:0] col_ff, col_in;
   logic [12:0] row_ff, row_in;
   logic        s1_valid_ff;
   logic        s1_in_map_ff;
   logic [15:0] s1_entry_ff;
   logic [13:0] s1_col_ff;
   logic [12:0] s1_row_ff;
   logic signed [15:0] s1_pixel_ff;
   logic        s1_last_ff, last_in;

   logic        accept, take_pixel, take_map;
   logic [14:0] w;
   logic [13:0] h;
   logic [14:0] col_inc;
   logic [13:0] row_inc;
   logic        col_end, row_end;
   logic [QCNT_SUM_W-1:0] used;

   assign used      = QCNT_SUM_W'(q_count) + QCNT_SUM_W'(s1_valid_ff);
   assign req_stall = used >= QCNT_SUM_W'(cuc_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign take_pixel = accept && (req_data.kind == cuc_pkg::KIND_PIXEL);
   assign take_map   = accept && (req_data.kind == cuc_pkg::KIND_MAP);

   assign w       = cuc_pkg::eff_width(cfg_in_width);
   assign h       = cuc_pkg::eff_height(cfg_in_height);
   assign col_inc = {1'b0, col_ff} + 15'd1;
   assign row_inc = {1'b0, row_ff} + 14'd1;
   assign col_end = col_inc >= w;
   assign row_end = row_inc >= h;
   assign last_in = col_end && row_end;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take_pixel) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_inc[12:0];
         end else begin
            col_in = col_inc[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= take_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (take_map && ({1'b0, req_data.map_index} < 15'(cuc_pkg::MAP_DEPTH))) begin
         map_mem[req_data.map_index[cuc_pkg::MAP_IDX_W-1:0]] <= req_data.map_value;
      end
      if (take_pixel) begin
         s1_entry_ff  <= map_mem[col_ff[cuc_pkg::MAP_IDX_W-1:0]];
         s1_in_map_ff <= {1'b0, col_ff} < 15'(cuc_pkg::MAP_DEPTH);
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_pixel_ff  <= req_data.pixel_value;
         s1_last_ff   <= last_in;
      end
   end

   always_comb begin
      q_push.valid       = s1_valid_ff;
      q_push.data.entry  = s1_in_map_ff ? s1_entry_ff : 16'd0;
      q_push.data.col    = s1_col_ff;
      q_push.data.row    = s1_row_ff;
      q_push.data.pixel  = s1_pixel_ff;
      q_push.data.last   = s1_last_ff;
   end

   a_pixel_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      take_pixel |=> s1_valid_ff)
      else $error("accepted pixel did not reach the map read stage");

endmodule
`default_nettype wire

>>> rtl/cuc_queue.sv
// short queue between the front end and the address back end
`default_nettype none
module cuc_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cuc_pkg::q_push_type        push,
   input  wire logic                       pop,
   output logic                            head_valid,
   output cuc_pkg::q_entry_type            head,
   output logic [cuc_pkg::QCNT_W-1:0]      count
);

   cuc_pkg::q_entry_type slots_ff [cuc_pkg::QUEUE_DEPTH];
   logic [cuc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cuc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cuc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_pop;

   localparam logic [cuc_pkg::QPTR_W-1:0] LAST_SLOT =
      cuc_pkg::QPTR_W'(cuc_pkg::QUEUE_DEPTH - 1);

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = count_ff != '0;
   assign head       = slots_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && !do_pop && (count_ff == cuc_pkg::QCNT_W'(cuc_pkg::QUEUE_DEPTH))))
      else $error("push into a full queue");

endmodule
`default_nettype wire

>>> rtl/cuc_back.sv
// back end: target row and column, range check, address multiply, result register
`default_nettype none
module cuc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire cuc_pkg::q_entry_type  head,
   output logic                       pop,
   input  wire logic [1:0]            cfg_mode,
   input  wire logic [13:0]           cfg_in_width,
   input  wire logic [13:0]           cfg_in_height,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output cuc_pkg::rsp_type           rsp_data
);

   localparam logic [14:0] FIXED_W = 15'(cuc_pkg::FIXED_OUT_SIZE);

   logic        advance;
   logic [14:0] w;
   logic [13:0] h;
   logic [14:0] ow;
   logic signed [16:0] oh_s, row_s, y_s;
   logic [13:0] x;
   logic        drop, oor_in, we_in;

   logic        a_valid_ff;
   logic [13:0] a_y_ff;
   logic [14:0] a_ow_ff;
   logic [13:0] a_x_ff;
   logic        a_we_ff, a_oor_ff, a_last_ff;
   logic signed [15:0] a_pixel_ff;

   logic [28:0] prod;
   logic [28:0] sum;
   logic        rsp_valid_ff;
   cuc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && head_valid;

   assign w     = cuc_pkg::eff_width(cfg_in_width);
   assign h     = cuc_pkg::eff_height(cfg_in_height);
   assign row_s = $signed({4'b0000, head.row});

   always_comb begin
      drop = 1'b0;
      unique case (cfg_mode)
         cuc_pkg::MODE_KEEP: begin
            ow   = {1'b0, w[14:1]};
            oh_s = $signed({2'b00, h, 1'b0});
            x    = head.entry[cuc_pkg::MAP_COL_MSB:0];
            y_s  = head.entry[cuc_pkg::MAP_FLIP_BIT] ? oh_s - 17'sd1 - row_s : row_s;
         end
         cuc_pkg::MODE_DROP: begin
            ow   = FIXED_W;
            oh_s = $signed({2'b00, FIXED_W});
            x    = head.entry[cuc_pkg::MAP_COL_MSB:0];
            y_s  = head.entry[cuc_pkg::MAP_FLIP_BIT] ? oh_s - 17'sd1 - row_s : row_s;
            drop = head.entry[cuc_pkg::MAP_ANC_BIT];
         end
         default: begin
            ow   = w;
            oh_s = $signed({3'b000, h});
            x    = head.col;
            y_s  = row_s;
         end
      endcase
      oor_in = !drop && (({1'b0, x} >= ow) || (y_s < 17'sd0) || (y_s >= oh_s));
      we_in  = !drop && !oor_in;
   end

   assign prod = 29'(a_y_ff) * 29'(a_ow_ff);
   assign sum  = prod + 29'(a_x_ff);

   always_comb begin
      rsp_data_in.write_address = a_we_ff ? sum[26:0] : 27'd0;
      rsp_data_in.pixel_out     = a_pixel_ff;
      rsp_data_in.write_enable  = a_we_ff;
      rsp_data_in.out_of_range  = a_oor_ff;
      rsp_data_in.frame_last    = a_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= head_valid;
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_y_ff      <= y_s[13:0];
         a_ow_ff     <= ow;
         a_x_ff      <= x;
         a_we_ff     <= we_in;
         a_oor_ff    <= oor_in;
         a_last_ff   <= head.last;
         a_pixel_ff  <= head.pixel;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.write_enable && rsp_data_ff.out_of_range))
      else $error("write enabled on an out of range target");

   a_blocked_address_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.write_enable) |-> (rsp_data_ff.write_address == 27'd0))
      else $error("nonzero address on a blocked write");

endmodule
`default_nettype wire
